// ----- design/ogd_pkg.sv -----
// ----------------------------------------------------------------------------
// ogd_pkg
// Shared types and constants for the occupancy grid obstacle dilation block.
// ----------------------------------------------------------------------------
package ogd_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam logic [7:0] MARK_VALUE = 8'd100;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_READ    = 2'd1;
  localparam logic [1:0] ACT_ENLARGE = 2'd2;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [7:0] occupancy_in;
    logic [7:0] flag_in;
    logic [7:0] enlarge_passes;
  } req_t;

  typedef struct packed {
    logic [7:0] occupancy_out;
    logic [7:0] flag_out;
    logic       done_res;
  } rsp_t;

endpackage

// ----- design/ogd_grid_mem.sv -----
// ----------------------------------------------------------------------------
// ogd_grid_mem
// Occupancy and flag byte memories, one registered read and one write port.
// ----------------------------------------------------------------------------
module ogd_grid_mem #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    occ_rd,
  output logic [7:0]    flag_rd,
  input  logic [AW-1:0] occ_waddr,
  input  logic          occ_we,
  input  logic [7:0]    occ_wdata,
  input  logic [AW-1:0] flag_waddr,
  input  logic          flag_we,
  input  logic [7:0]    flag_wdata
);

  logic [7:0] occ_mem  [2**AW];
  logic [7:0] flag_mem [2**AW];

  always_ff @(posedge clk) begin
    if (occ_we) begin
      occ_mem[occ_waddr] <= occ_wdata;
    end
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    occ_rd  <= occ_mem[rd_addr];
    flag_rd <= flag_mem[rd_addr];
  end

endmodule

// ----- design/ogd_mark_mem.sv -----
// ----------------------------------------------------------------------------
// ogd_mark_mem
// One-bit source mark memory, rebuilt at the start of every dilation pass.
// ----------------------------------------------------------------------------
module ogd_mark_mem #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic          rd_data,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic          wdata
);

  logic mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/occupancy_grid_obstacle_dilation.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_obstacle_dilation
// Occupancy grid with 3x3 keep-out dilation, built around grid memories.
// ----------------------------------------------------------------------------
// write or unused action: result loaded on acceptance; read: loaded in ST_RD
// enlarge with zero passes: ST_CLR clears MARK_VALUE flags, one cell per cycle through the
// flag memory, then ST_FIN; with P passes, each pass sweeps the W*H cells for the
// snapshot, then steps each cell through the nine mark memory reads of its window
// one item at a time; a new item is taken once idle and the result register is free
// reset clears control and sets both grid sizes to 2; grid memories are not cleared
module occupancy_grid_obstacle_dilation #(
  parameter int MAX_WIDTH  = ogd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = ogd_pkg::MAX_HEIGHT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_data,
  input  logic          req_valid,
  output logic          req_stall,
  input  ogd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ogd_pkg::rsp_t rsp
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_SNAP = 3'd2;
  localparam logic [2:0] ST_SDRN = 3'd3;
  localparam logic [2:0] ST_DIL  = 3'd4;
  localparam logic [2:0] ST_CLR  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  localparam logic [3:0] K_LAST = 4'd9;

  logic [2:0]    state;
  logic [6:0]    grid_width;
  logic [6:0]    grid_height;
  logic [XW:0]   eff_w;
  logic [YW:0]   eff_h;
  logic [XW-1:0] last_x;
  logic [YW-1:0] last_y;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic          last_cell;
  logic [7:0]    pass_left;
  logic          rd_inside;
  logic [3:0]    k;
  logic          v_q;
  logic          acc_hit;
  logic [7:0]    flag_q;
  logic          p_v;
  logic          p_snap;
  logic [AW-1:0] p_addr;

  logic          accept;
  logic          in_grid;
  logic [AW-1:0] req_addr;
  logic [AW-1:0] cur_addr;
  logic          rsp_load;
  ogd_pkg::rsp_t rsp_next;

  logic [7:0]    occ_rd;
  logic [7:0]    flag_rd;
  logic          mark_rd;
  logic [AW-1:0] grid_raddr;
  logic          occ_we;
  logic          flag_we;
  logic [AW-1:0] flag_waddr;
  logic [7:0]    flag_wdata;
  logic          mark_we;
  logic          mark_wdata;

  logic [1:0]    dxc;
  logic [1:0]    dyc;
  logic          nv;
  logic [XW-1:0] nx;
  logic [YW-1:0] ny;
  logic          hit;
  logic          dil_we;

  // effective grid size saturated to [2, max]
  always_comb begin
    if (grid_width < 7'd2) begin
      eff_w = (XW+1)'(2);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      eff_w = (XW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (XW+1)'(grid_width);
    end
    if (grid_height < 7'd2) begin
      eff_h = (YW+1)'(2);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      eff_h = (YW+1)'(MAX_HEIGHT);
    end else begin
      eff_h = (YW+1)'(grid_height);
    end
  end

  assign last_x    = XW'(eff_w - (XW+1)'(1));
  assign last_y    = YW'(eff_h - (YW+1)'(1));
  assign last_cell = (cx == last_x) && (cy == last_y);
  assign cur_addr  = {cy, cx};

  assign req_stall = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign in_grid   = (32'(req.cell_x) < 32'(eff_w)) && (32'(req.cell_y) < 32'(eff_h));
  assign req_addr  = {YW'(req.cell_y), XW'(req.cell_x)};

  // window position for the mark read issued at step k
  always_comb begin
    case (k)
      4'd0: begin dxc = 2'd0; dyc = 2'd0; end
      4'd1: begin dxc = 2'd1; dyc = 2'd0; end
      4'd2: begin dxc = 2'd2; dyc = 2'd0; end
      4'd3: begin dxc = 2'd0; dyc = 2'd1; end
      4'd4: begin dxc = 2'd1; dyc = 2'd1; end
      4'd5: begin dxc = 2'd2; dyc = 2'd1; end
      4'd6: begin dxc = 2'd0; dyc = 2'd2; end
      4'd7: begin dxc = 2'd1; dyc = 2'd2; end
      4'd8: begin dxc = 2'd2; dyc = 2'd2; end
      default: begin dxc = 2'd1; dyc = 2'd1; end
    endcase
  end

  always_comb begin
    nx = cx;
    ny = cy;
    nv = 1'b1;
    case (dxc)
      2'd0: begin nx = cx - XW'(1); nv = nv && (cx != '0); end
      2'd2: begin nx = cx + XW'(1); nv = nv && (cx != last_x); end
      default: ;
    endcase
    case (dyc)
      2'd0: begin ny = cy - YW'(1); nv = nv && (cy != '0); end
      2'd2: begin ny = cy + YW'(1); nv = nv && (cy != last_y); end
      default: ;
    endcase
    // the cell itself is its own neighbor only through edge clamping
    if (dxc == 2'd1 && dyc == 2'd1) begin
      nv = (cx == '0) || (cx == last_x) || (cy == '0) || (cy == last_y);
    end
  end

  assign hit    = acc_hit || (v_q && mark_rd);
  assign dil_we = (state == ST_DIL) && (k == K_LAST) && (flag_q == '0) && hit;

  assign grid_raddr = (state == ST_IDLE) ? req_addr : cur_addr;
  assign occ_we     = accept && (req.action == ogd_pkg::ACT_WRITE) && in_grid;
  assign mark_we    = p_v && p_snap;
  assign mark_wdata = (occ_rd == ogd_pkg::MARK_VALUE) || (flag_rd == ogd_pkg::MARK_VALUE);

  always_comb begin
    flag_we    = 1'b0;
    flag_waddr = req_addr;
    flag_wdata = req.flag_in;
    if (occ_we) begin
      flag_we = 1'b1;
    end else if (p_v && !p_snap) begin
      flag_we    = (flag_rd == ogd_pkg::MARK_VALUE);
      flag_waddr = p_addr;
      flag_wdata = '0;
    end else if (dil_we) begin
      flag_we    = 1'b1;
      flag_waddr = cur_addr;
      flag_wdata = ogd_pkg::MARK_VALUE;
    end
  end

  always_comb begin
    rsp_load = (accept && req.action != ogd_pkg::ACT_READ &&
                req.action != ogd_pkg::ACT_ENLARGE) ||
               (state == ST_RD) || (state == ST_FIN);
    rsp_next.occupancy_out = (state == ST_RD && rd_inside) ? occ_rd : '0;
    rsp_next.flag_out      = (state == ST_RD && rd_inside) ? flag_rd : '0;
    rsp_next.done_res      = 1'b1;
  end

  ogd_grid_mem #(.AW(AW)) u_grid (
    .clk        (clk),
    .rd_addr    (grid_raddr),
    .occ_rd     (occ_rd),
    .flag_rd    (flag_rd),
    .occ_waddr  (req_addr),
    .occ_we     (occ_we),
    .occ_wdata  (req.occupancy_in),
    .flag_waddr (flag_waddr),
    .flag_we    (flag_we),
    .flag_wdata (flag_wdata)
  );

  ogd_mark_mem #(.AW(AW)) u_mark (
    .clk     (clk),
    .rd_addr ({ny, nx}),
    .rd_data (mark_rd),
    .we      (mark_we),
    .wr_addr (p_addr),
    .wdata   (mark_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      grid_width  <= 7'd2;
      grid_height <= 7'd2;
      rsp_valid   <= 1'b0;
      p_v         <= 1'b0;
      k           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ogd_pkg::REG_WIDTH:  grid_width  <= cfg_data;
          ogd_pkg::REG_HEIGHT: grid_height <= cfg_data;
          default: ;
        endcase
      end
      p_v <= 1'b0;
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        rsp       <= rsp_next;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cx        <= '0;
            cy        <= '0;
            pass_left <= req.enlarge_passes;
            rd_inside <= in_grid;
            if (req.action == ogd_pkg::ACT_READ) begin
              state <= ST_RD;
            end else if (req.action == ogd_pkg::ACT_ENLARGE) begin
              state <= (req.enlarge_passes == '0) ? ST_CLR : ST_SNAP;
            end
          end
        end
        ST_RD: begin
          state <= ST_IDLE;
        end
        ST_SNAP, ST_CLR: begin
          // read issued now, write-back in the next cycle from the p_* stage
          p_v    <= 1'b1;
          p_snap <= (state == ST_SNAP);
          p_addr <= cur_addr;
          if (last_cell) begin
            cx    <= '0;
            cy    <= '0;
            state <= (state == ST_SNAP) ? ST_SDRN : ST_FIN;
          end else if (cx == last_x) begin
            cx <= '0;
            cy <= cy + YW'(1);
          end else begin
            cx <= cx + XW'(1);
          end
        end
        ST_SDRN: begin
          k     <= '0;
          state <= ST_DIL;
        end
        ST_DIL: begin
          v_q <= nv;
          if (k == '0) begin
            acc_hit <= 1'b0;
          end else begin
            acc_hit <= hit;
          end
          if (k == 4'd1) begin
            flag_q <= flag_rd;
          end
          if (k == K_LAST) begin
            k <= '0;
            if (last_cell) begin
              cx <= '0;
              cy <= '0;
              if (pass_left == 8'd1) begin
                state <= ST_FIN;
              end else begin
                pass_left <= pass_left - 8'd1;
                state     <= ST_SNAP;
              end
            end else if (cx == last_x) begin
              cx <= '0;
              cy <= cy + YW'(1);
            end else begin
              cx <= cx + XW'(1);
            end
          end else begin
            k <= k + 4'd1;
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> (!rsp_valid || !rsp_stall))
    else $error("result register overwritten");

  a_dil_zero: assert property (@(posedge clk) disable iff (rst)
    dil_we |-> (flag_q == '0))
    else $error("dilation wrote over a nonzero flag");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIL) |-> (k <= K_LAST))
    else $error("window step counter out of range");

  a_snap_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIL && k == '0 && $past(state) == ST_SDRN) |-> !p_v)
    else $error("mark write pending at dilation start");

endmodule

// ----- dv/tb_occupancy_grid_obstacle_dilation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_occupancy_grid_obstacle_dilation
// Streams cell writes, reads and obstacle enlargement through the grid block
// and checks every response against a scoreboard that keeps its own grid copy.
// ----------------------------------------------------------------------------
module tb_occupancy_grid_obstacle_dilation;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int GRID_W = ogd_pkg::MAX_WIDTH_DEF;
  localparam int GRID_H = ogd_pkg::MAX_HEIGHT_DEF;
  localparam int GRID_CELLS = GRID_W * GRID_H;
  localparam int STALL_LIMIT = 400000;

  class grid_scoreboard;
    logic [7:0] occ_grid[GRID_CELLS];
    logic [7:0] flag_grid[GRID_CELLS];
    bit snap[GRID_CELLS];
    int cols = 2;
    int rows = 2;
    ogd_pkg::rsp_t expected_q[$];
    int errors = 0;

    function void set_size(logic idx, logic [6:0] v);
      int s;
      s = (v < 2) ? 2 : v;
      if (idx == ogd_pkg::REG_WIDTH) cols = (s > GRID_W) ? GRID_W : s;
      else rows = (s > GRID_H) ? GRID_H : s;
    endfunction

    function void mark(int x, int y);
      if (flag_grid[y * GRID_W + x] == 8'd0)
        flag_grid[y * GRID_W + x] = ogd_pkg::MARK_VALUE;
    endfunction

    function void note_request(ogd_pkg::req_t r);
      ogd_pkg::rsp_t e;
      int a, xl, xr, yu, yd;
      bit in_grid;
      e = '0;
      e.done_res = 1'b1;
      in_grid = (r.cell_x < cols) && (r.cell_y < rows);
      a = r.cell_y * GRID_W + r.cell_x;
      case (r.action)
        ogd_pkg::ACT_WRITE: begin
          if (in_grid) begin
            occ_grid[a] = r.occupancy_in;
            flag_grid[a] = r.flag_in;
          end
        end
        ogd_pkg::ACT_READ: begin
          if (in_grid) begin
            e.occupancy_out = occ_grid[a];
            e.flag_out = flag_grid[a];
          end
        end
        ogd_pkg::ACT_ENLARGE: begin
          if (r.enlarge_passes == 0) begin
            for (int y = 0; y < rows; y++)
              for (int x = 0; x < cols; x++)
                if (flag_grid[y * GRID_W + x] == ogd_pkg::MARK_VALUE)
                  flag_grid[y * GRID_W + x] = 8'd0;
          end else begin
            for (int p = 0; p < r.enlarge_passes; p++) begin
              for (int y = 0; y < rows; y++)
                for (int x = 0; x < cols; x++)
                  snap[y * GRID_W + x] = (occ_grid[y * GRID_W + x] == ogd_pkg::MARK_VALUE)
                    || (flag_grid[y * GRID_W + x] == ogd_pkg::MARK_VALUE);
              for (int y = 0; y < rows; y++)
                for (int x = 0; x < cols; x++)
                  if (snap[y * GRID_W + x]) begin
                    xl = (x > 0) ? x - 1 : 0;
                    xr = (x + 1 < cols) ? x + 1 : cols - 1;
                    yu = (y > 0) ? y - 1 : 0;
                    yd = (y + 1 < rows) ? y + 1 : rows - 1;
                    mark(xl, y); mark(xr, y); mark(x, yu); mark(x, yd);
                    mark(xl, yu); mark(xl, yd); mark(xr, yu); mark(xr, yd);
                  end
            end
          end
        end
        default: ;
      endcase
      expected_q = {expected_q, e};
    endfunction

    function void check_response(ogd_pkg::rsp_t got);
      ogd_pkg::rsp_t e;
      if (expected_q.size() == 0) begin
        $error("response with nothing expected: %h", got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.occupancy_out !== e.occupancy_out) begin
        $error("occupancy_out expected %0d actual %0d", e.occupancy_out, got.occupancy_out);
        errors++;
      end
      if (got.flag_out !== e.flag_out) begin
        $error("flag_out expected %0d actual %0d", e.flag_out, got.flag_out);
        errors++;
      end
      if (got.done_res !== e.done_res) begin
        $error("done_res expected %0d actual %0d", e.done_res, got.done_res);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [6:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  ogd_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  ogd_pkg::rsp_t rsp;

  grid_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  occupancy_grid_obstacle_dilation i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #1 clk = ~clk;

  // response side: check transfers, pick the next stall value
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_response(rsp);
    if (hold_request) begin
      hold_left = 300;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send_item(ogd_pkg::req_t r);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic set_grid(logic [6:0] w, logic [6:0] h);
    req_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= ogd_pkg::REG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    sb.set_size(ogd_pkg::REG_WIDTH, w);
    cfg_index <= ogd_pkg::REG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    sb.set_size(ogd_pkg::REG_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  function automatic ogd_pkg::req_t cell_op(logic [1:0] a, int x, int y, int occ, int flg,
                                            int p);
    ogd_pkg::req_t r;
    r.action = a;
    r.cell_x = 6'(x);
    r.cell_y = 6'(y);
    r.occupancy_in = 8'(occ);
    r.flag_in = 8'(flg);
    r.enlarge_passes = 8'(p);
    return r;
  endfunction

  function automatic logic [7:0] pick_level();
    int k;
    k = $urandom_range(9);
    if (k < 3) return ogd_pkg::MARK_VALUE;
    if (k < 7) return 8'd0;
    return 8'($urandom_range(255));
  endfunction

  function automatic ogd_pkg::req_t random_item();
    ogd_pkg::req_t r;
    int k, area;
    r = '0;
    r.occupancy_in = pick_level();
    r.flag_in = pick_level();
    r.enlarge_passes = 8'($urandom_range(255));
    k = $urandom_range(99);
    r.action = (k < 46) ? ogd_pkg::ACT_WRITE : (k < 90) ? ogd_pkg::ACT_READ :
               (k < 95) ? ACT_NONE : ogd_pkg::ACT_ENLARGE;
    if ($urandom_range(99) < 85) begin
      r.cell_x = 6'($urandom_range(sb.cols - 1));
      r.cell_y = 6'($urandom_range(sb.rows - 1));
    end else begin
      r.cell_x = 6'($urandom_range(63));
      r.cell_y = 6'($urandom_range(63));
    end
    // keep full-size sweeps short, allow deep runs only on tiny grids
    area = sb.cols * sb.rows;
    if (r.action == ogd_pkg::ACT_ENLARGE) begin
      if (area > 256) r.enlarge_passes = 8'($urandom_range(1));
      else if (area > 16 || $urandom_range(9) != 0) r.enlarge_passes = 8'($urandom_range(3));
    end
    return r;
  endfunction

  task automatic random_run(logic [6:0] w, logic [6:0] h, int n);
    set_grid(w, h);
    for (int i = 0; i < n; i++) send_item(random_item());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every cell that a later grid shape can reach
    set_grid(7'd64, 7'd64);
    for (int y = 0; y < 64; y++)
      for (int x = 0; x < 64; x++)
        if (y < 2 || x < 2 || (x < 7 && y < 9))
          send_item(cell_op(ogd_pkg::ACT_WRITE, x, y, pick_level(), pick_level(), 0));

    send_item(cell_op(ogd_pkg::ACT_WRITE, 63, 63, 255, 255, 255));
    send_item(cell_op(ogd_pkg::ACT_READ, 63, 63, 0, 0, 0));
    set_grid(7'd64, 7'd2);
    send_item(cell_op(ogd_pkg::ACT_ENLARGE, 0, 0, 0, 0, 1));
    send_item(cell_op(ogd_pkg::ACT_READ, 62, 1, 0, 0, 0));

    set_grid(7'd0, 7'd1);
    send_item(cell_op(ogd_pkg::ACT_WRITE, 0, 0, 100, 0, 0));
    send_item(cell_op(ogd_pkg::ACT_WRITE, 1, 0, 0, 0, 0));
    send_item(cell_op(ogd_pkg::ACT_WRITE, 0, 1, 0, 7, 0));
    send_item(cell_op(ogd_pkg::ACT_WRITE, 1, 1, 0, 0, 0));
    send_item(cell_op(ogd_pkg::ACT_WRITE, 5, 1, 100, 100, 0));
    send_item(cell_op(ogd_pkg::ACT_READ, 1, 7, 0, 0, 0));
    send_item(cell_op(ACT_NONE, 63, 63, 255, 255, 255));
    send_item(cell_op(ogd_pkg::ACT_ENLARGE, 0, 0, 0, 0, 1));
    send_item(cell_op(ogd_pkg::ACT_READ, 1, 1, 0, 0, 0));
    send_item(cell_op(ogd_pkg::ACT_READ, 0, 1, 0, 0, 0));
    send_item(cell_op(ogd_pkg::ACT_ENLARGE, 0, 0, 0, 0, 0));
    send_item(cell_op(ogd_pkg::ACT_READ, 1, 0, 0, 0, 0));
    send_item(cell_op(ogd_pkg::ACT_WRITE, 1, 1, 100, 0, 0));
    send_item(cell_op(ogd_pkg::ACT_ENLARGE, 0, 0, 0, 0, 255));
    send_item(cell_op(ogd_pkg::ACT_READ, 0, 0, 0, 0, 0));

    tx_idle_pct = 25;
    rx_stall_pct = 88;
    random_run(7'd2, 7'd2, 60);
    random_run(7'd5, 7'd3, 60);
    random_run(7'd4, 7'd4, 60);

    tx_idle_pct = 88;
    rx_stall_pct = 25;
    set_grid(7'd0, 7'd127);
    hold_request = 1'b1;
    for (int i = 0; i < 60; i++) send_item(random_item());
    random_run(7'd127, 7'd1, 60);
    random_run(7'd7, 7'd9, 60);

    tx_idle_pct = 0;
    rx_stall_pct = 0;
    random_run(7'd64, 7'd2, 60);
    random_run(7'd2, 7'd3, 60);

    req_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
